// ----- hdl/lpg_pkg.sv -----
package lpg_pkg;

    localparam int COORD_BITS = 10;
    localparam int INK_BITS   = 8;
    localparam int ERR_BITS   = COORD_BITS + 1;

    // request function codes
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        KIND_XMAJOR = 2'd0,
        KIND_YMAJOR = 2'd1,
        KIND_DIAG   = 2'd2
    } line_kind_t;

    typedef struct packed {
        logic                  func;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
        logic [INK_BITS-1:0]   ink;
    } req_word_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [INK_BITS-1:0]   pixel_ink;
        logic                  last;
    } pix_word_t;

    // line parameters derived from the end points on a load
    typedef struct packed {
        logic                  x_up;
        logic                  y_up;
        line_kind_t            kind;
        logic [COORD_BITS-1:0] major_len;
        logic [COORD_BITS-1:0] minor_len;
    } line_setup_t;

endpackage

// ----- hdl/lpg_setup.sv -----
module lpg_setup
    import lpg_pkg::*;
(
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output line_setup_t           setup
);

    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;

    // absolute extents on each axis
    always_comb
    begin
        adx = (end_x >= start_x) ? (end_x - start_x) : (start_x - end_x);
        ady = (end_y >= start_y) ? (end_y - start_y) : (start_y - end_y);
    end

    // direction, line kind and major/minor lengths
    always_comb
    begin
        setup.x_up = (end_x > start_x);
        setup.y_up = (end_y > start_y);
        priority if (adx > ady)
        begin
            setup.kind      = KIND_XMAJOR;
            setup.major_len = adx;
            setup.minor_len = ady;
        end
        else if (adx < ady)
        begin
            setup.kind      = KIND_YMAJOR;
            setup.major_len = ady;
            setup.minor_len = adx;
        end
        else
        begin
            setup.kind      = KIND_DIAG;
            setup.major_len = adx;
            setup.minor_len = ady;
        end
    end

endmodule

// ----- hdl/lpg_walker.sv -----
module lpg_walker
    import lpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  req_word_t req,
    output logic      res_valid,
    output pix_word_t res
);

    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [ERR_BITS-1:0]   err_acc_reg, err_acc_next;
    logic [COORD_BITS-1:0] steps_left_reg, steps_left_next;
    logic [COORD_BITS-1:0] major_len_reg, major_len_next;
    logic [COORD_BITS-1:0] minor_len_reg, minor_len_next;
    logic                  x_up_reg, x_up_next;
    logic                  y_up_reg, y_up_next;
    line_kind_t            kind_reg, kind_next;
    logic [INK_BITS-1:0]   ink_reg, ink_next;

    line_setup_t           setup;
    logic [COORD_BITS-1:0] x_moved;
    logic [COORD_BITS-1:0] y_moved;
    logic                  minor_step;
    logic [ERR_BITS-1:0]   err_mid;
    logic [ERR_BITS-1:0]   err_stepped;

    lpg_setup u_setup (
        .start_x (req.start_x),
        .start_y (req.start_y),
        .end_x   (req.end_x),
        .end_y   (req.end_y),
        .setup   (setup)
    );

    // one-pixel moves and error update
    always_comb
    begin
        x_moved     = x_up_reg ? (cur_x_reg + COORD_BITS'(1)) : (cur_x_reg - COORD_BITS'(1));
        y_moved     = y_up_reg ? (cur_y_reg + COORD_BITS'(1)) : (cur_y_reg - COORD_BITS'(1));
        minor_step  = (err_acc_reg >= {1'b0, major_len_reg});
        err_mid     = minor_step ? (err_acc_reg - {1'b0, major_len_reg}) : err_acc_reg;
        err_stepped = err_mid + {1'b0, minor_len_reg};
    end

    // next state and result
    always_comb
    begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        err_acc_next    = err_acc_reg;
        steps_left_next = steps_left_reg;
        major_len_next  = major_len_reg;
        minor_len_next  = minor_len_reg;
        x_up_next       = x_up_reg;
        y_up_next       = y_up_reg;
        kind_next       = kind_reg;
        ink_next        = ink_reg;
        res_valid       = 1'b0;

        if (accept)
        begin
            if (req.func == FUNC_LOAD)
            begin
                cur_x_next      = req.start_x;
                cur_y_next      = req.start_y;
                err_acc_next    = '0;
                steps_left_next = setup.major_len;
                major_len_next  = setup.major_len;
                minor_len_next  = setup.minor_len;
                x_up_next       = setup.x_up;
                y_up_next       = setup.y_up;
                kind_next       = setup.kind;
                ink_next        = req.ink;
                res_valid       = 1'b1;
            end
            else if (steps_left_reg != '0)
            begin
                unique case (kind_reg)
                    KIND_XMAJOR:
                    begin
                        cur_x_next   = x_moved;
                        cur_y_next   = minor_step ? y_moved : cur_y_reg;
                        err_acc_next = err_stepped;
                    end
                    KIND_YMAJOR:
                    begin
                        cur_y_next   = y_moved;
                        cur_x_next   = minor_step ? x_moved : cur_x_reg;
                        err_acc_next = err_stepped;
                    end
                    default:
                    begin
                        // diagonal: both axes move
                        cur_x_next = x_moved;
                        cur_y_next = y_moved;
                    end
                endcase
                steps_left_next = steps_left_reg - COORD_BITS'(1);
                res_valid       = 1'b1;
            end
        end

        res.pixel_x   = cur_x_next;
        res.pixel_y   = cur_y_next;
        res.pixel_ink = ink_next;
        res.last      = (steps_left_next == '0);
    end

    // line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            err_acc_reg    <= '0;
            steps_left_reg <= '0;
            major_len_reg  <= '0;
            minor_len_reg  <= '0;
            x_up_reg       <= 1'b0;
            y_up_reg       <= 1'b0;
            kind_reg       <= KIND_XMAJOR;
            ink_reg        <= '0;
        end
        else
        begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            err_acc_reg    <= err_acc_next;
            steps_left_reg <= steps_left_next;
            major_len_reg  <= major_len_next;
            minor_len_reg  <= minor_len_next;
            x_up_reg       <= x_up_next;
            y_up_reg       <= y_up_next;
            kind_reg       <= kind_next;
            ink_reg        <= ink_next;
        end
    end

    // an advance past the end of the line gives no word
    a_no_pixel_past_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.func == FUNC_ADVANCE && steps_left_reg == '0) |-> !res_valid)
        else $error("pixel produced past end of line");

    // every advance inside a line counts down by one
    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.func == FUNC_ADVANCE && steps_left_reg != '0)
        |=> (steps_left_reg == $past(steps_left_reg) - COORD_BITS'(1)))
        else $error("step counter did not decrement");

    // a load always gives its first pixel
    a_load_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.func == FUNC_LOAD) |-> res_valid)
        else $error("load produced no pixel");

endmodule

// ----- hdl/lpg_out_buf.sv -----
module lpg_out_buf
    import lpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      res_valid,
    input  pix_word_t res,
    output logic      space,
    output logic      pix_valid,
    input  logic      pix_ready,
    output pix_word_t pix
);

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    pix_word_t main_reg, main_next;
    pix_word_t skid_reg, skid_next;
    logic      take;

    assign take      = main_valid_reg && pix_ready;
    assign space     = !skid_valid_reg;
    assign pix_valid = main_valid_reg;
    assign pix       = main_reg;

    // two-entry output stage: main register drives the port, skid catches a stall
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!main_valid_reg || take)
            begin
                main_next       = res;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    // skid entry only fills behind a full main entry
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid with main entry empty");

    // no word arrives while the stage is full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !skid_valid_reg)
        else $error("word arrived with output stage full");

    // draining the skid entry keeps the main entry occupied
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && take) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid entry lost on drain");

endmodule

// ----- hdl/line_pixel_generator.sv -----
// Line pixel generator: a load word (func = 0) takes two end points and an ink
// value and produces the first pixel; each advance word (func = 1) produces the
// next pixel of the line along the major axis, stepping the minor axis when the
// error term reaches the major length; equal extents give a pure diagonal. The
// final pixel carries last = 1, and an advance after it, or before any load,
// is accepted and produces no word. One request word is taken every cycle: the
// step logic is a single compare, subtract, add and increment between the line
// state registers and a two-entry output stage; each pixel is registered in the
// main or skid entry before the pix port, and req_ready drops only when both
// output entries are full. No clipping is done; coordinates wrap.
module line_pixel_generator
    import lpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_word_t req,
    output logic      pix_valid,
    input  logic      pix_ready,
    output pix_word_t pix
);

    logic      accept;
    logic      res_valid;
    pix_word_t res;
    logic      space;

    assign req_ready = space;
    assign accept    = req_valid && space;

    lpg_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .res_valid (res_valid),
        .res       (res)
    );

    lpg_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .space     (space),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import lpg_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_LIMIT = 10;

    // Pixel checker: follows the line state and holds the pixels still due
    class pixel_checker;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [ERR_BITS-1:0]   err_term;
        logic [COORD_BITS-1:0] steps_to_go;
        logic [COORD_BITS-1:0] major_len;
        logic [COORD_BITS-1:0] minor_len;
        logic                  x_up;
        logic                  y_up;
        line_kind_t            kind;
        logic [INK_BITS-1:0]   ink_held;
        pix_word_t             expected_pixels[$];
        int unsigned           mismatches;
        int unsigned           pixels_checked;
        int unsigned           lines_loaded;
        int unsigned           dead_advances;

        function new();
            pos_x          = '0;
            pos_y          = '0;
            err_term       = '0;
            steps_to_go    = '0;
            major_len      = '0;
            minor_len      = '0;
            x_up           = 1'b0;
            y_up           = 1'b0;
            kind           = KIND_XMAJOR;
            ink_held       = '0;
            mismatches     = 0;
            pixels_checked = 0;
            lines_loaded   = 0;
            dead_advances  = 0;
        endfunction

        function logic [COORD_BITS-1:0] step_coord(logic [COORD_BITS-1:0] v, logic up);
            return up ? v + 1'b1 : v - 1'b1;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // Accepted request word: update line state, queue the pixel it yields
        function void note_request(req_word_t w);
            pix_word_t p;
            logic [COORD_BITS-1:0] dx;
            logic [COORD_BITS-1:0] dy;
            if (w.func == FUNC_LOAD)
            begin
                x_up = (w.end_x > w.start_x);
                y_up = (w.end_y > w.start_y);
                dx = (w.end_x >= w.start_x) ? w.end_x - w.start_x : w.start_x - w.end_x;
                dy = (w.end_y >= w.start_y) ? w.end_y - w.start_y : w.start_y - w.end_y;
                if (dx > dy)
                begin
                    kind      = KIND_XMAJOR;
                    major_len = dx;
                    minor_len = dy;
                end
                else if (dx < dy)
                begin
                    kind      = KIND_YMAJOR;
                    major_len = dy;
                    minor_len = dx;
                end
                else
                begin
                    kind      = KIND_DIAG;
                    major_len = dx;
                    minor_len = dy;
                end
                pos_x       = w.start_x;
                pos_y       = w.start_y;
                err_term    = '0;
                steps_to_go = major_len;
                ink_held    = w.ink;
                lines_loaded++;
            end
            else if (steps_to_go == 0)
            begin
                // line finished or never loaded: no pixel, state kept
                dead_advances++;
                return;
            end
            else
            begin
                case (kind)
                    KIND_XMAJOR:
                    begin
                        if (err_term >= major_len)
                        begin
                            pos_y    = step_coord(pos_y, y_up);
                            err_term = err_term - major_len;
                        end
                        pos_x    = step_coord(pos_x, x_up);
                        err_term = err_term + minor_len;
                    end
                    KIND_YMAJOR:
                    begin
                        if (err_term >= major_len)
                        begin
                            pos_x    = step_coord(pos_x, x_up);
                            err_term = err_term - major_len;
                        end
                        pos_y    = step_coord(pos_y, y_up);
                        err_term = err_term + minor_len;
                    end
                    default:
                    begin
                        // diagonal: both axes move every step
                        pos_x = step_coord(pos_x, x_up);
                        pos_y = step_coord(pos_y, y_up);
                    end
                endcase
                steps_to_go = steps_to_go - 1'b1;
            end
            p.pixel_x   = pos_x;
            p.pixel_y   = pos_y;
            p.pixel_ink = ink_held;
            p.last      = (steps_to_go == 0);
            expected_pixels.push_back(p);
        endfunction

        // Accepted pixel word: compare against the oldest expected pixel
        function void check_pixel(pix_word_t got);
            pix_word_t want;
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected pixel x=%0d y=%0d ink=%0d last=%0b", $time,
                             got.pixel_x, got.pixel_y, got.pixel_ink, got.last);
                return;
            end
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
                got.pixel_ink !== want.pixel_ink || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: pixel mismatch want x=%0d y=%0d ink=%0d last=%0b",
                             $time, want.pixel_x, want.pixel_y, want.pixel_ink, want.last);
                    $display("    got x=%0d y=%0d ink=%0d last=%0b",
                             got.pixel_x, got.pixel_y, got.pixel_ink, got.last);
                end
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_word_t req = '0;
    logic      pix_valid;
    logic      pix_ready = 1'b0;
    pix_word_t pix;

    logic         rx_hold = 1'b0;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    int           items_sent = 0;
    int unsigned  cycle_count = 0;
    pixel_checker board;

    line_pixel_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixels still due", cycle_count,
                     board.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // pixel port back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            pix_ready <= 1'b0;
        else
            pix_ready <= !rx_hold && ($urandom_range(99, 0) >= rx_idle_pct);
    end

    // monitors for both handshakes
    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
            board.note_request(req);
        if (rst_n && pix_valid && pix_ready)
            board.check_pixel(pix);
    end

    function automatic req_word_t random_word();
        req_word_t w;
        w.func    = 1'($urandom());
        w.start_x = COORD_BITS'($urandom());
        w.start_y = COORD_BITS'($urandom());
        w.end_x   = COORD_BITS'($urandom());
        w.end_y   = COORD_BITS'($urandom());
        w.ink     = INK_BITS'($urandom());
        return w;
    endfunction

    // end point within a short reach of c, kept on screen
    function automatic logic [COORD_BITS-1:0] near_coord(logic [COORD_BITS-1:0] c);
        int lo;
        int hi;
        lo = (int'(c) > 15) ? int'(c) - 15 : 0;
        hi = (int'(c) < 1008) ? int'(c) + 15 : 1023;
        return COORD_BITS'($urandom_range(hi, lo));
    endfunction

    // Offer one request word, with random idle cycles first; return once taken
    task automatic send_word(req_word_t w);
        int gaps;
        gaps = 0;
        while (gaps < 40 && $urandom_range(99, 0) < tx_idle_pct)
            gaps++;
        if (gaps > 0)
        begin
            req_valid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_load(int sx, int sy, int ex, int ey, int ink_val);
        req_word_t w;
        w.func    = FUNC_LOAD;
        w.start_x = COORD_BITS'(sx);
        w.start_y = COORD_BITS'(sy);
        w.end_x   = COORD_BITS'(ex);
        w.end_y   = COORD_BITS'(ey);
        w.ink     = INK_BITS'(ink_val);
        send_word(w);
    endtask

    task automatic send_advance(int count);
        req_word_t w;
        repeat (count)
        begin
            w      = random_word();
            w.func = FUNC_ADVANCE;
            send_word(w);
        end
    endtask

    // Sender pauses until every pixel due has come out
    task automatic wait_for_pixels();
        req_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic hold_receiver(int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        rx_hold <= 1'b0;
    endtask

    // Mostly whole lines with random content; some cut short, some overrun,
    // a few long lines and some raw noise words
    task automatic run_random(int upto);
        req_word_t w;
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        int steps;
        int n;
        while (items_sent < upto)
        begin
            if ($urandom_range(99, 0) < 6)
                send_word(random_word());
            else
            begin
                w      = random_word();
                w.func = FUNC_LOAD;
                if ($urandom_range(59, 0) != 0)
                begin
                    w.end_x = near_coord(w.start_x);
                    w.end_y = near_coord(w.start_y);
                end
                send_word(w);
                dx = (w.end_x >= w.start_x) ? w.end_x - w.start_x : w.start_x - w.end_x;
                dy = (w.end_y >= w.start_y) ? w.end_y - w.start_y : w.start_y - w.end_y;
                steps = (dx > dy) ? int'(dx) : int'(dy);
                n = steps;
                if ($urandom_range(9, 0) == 0)
                    n = $urandom_range(steps, 0);
                else if ($urandom_range(4, 0) == 0)
                    n = steps + $urandom_range(2, 1);
                while (n > 0 && items_sent < upto)
                begin
                    send_advance(1);
                    n--;
                end
            end
        end
    endtask

    initial
    begin
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // phase 1: slow receiver
        tx_idle_pct = 28;
        rx_idle_pct = 88;
        @(posedge clk);

        // directed: advance with no line loaded
        send_advance(1);
        // zero-length line, then an advance past its end
        send_load(5, 5, 5, 5, 255);
        send_advance(1);
        // x-major rising, shallow slope, overrun by one
        send_load(0, 0, 3, 1, 0);
        send_advance(4);
        // y-major falling from the far corner
        send_load(1023, 1023, 1021, 1019, 170);
        send_advance(4);
        // falling diagonal
        send_load(10, 1023, 8, 1021, 85);
        send_advance(2);
        // full-width x-major line, reloaded partway
        send_load(1023, 0, 0, 7, 1);
        send_advance(2);
        // all-ones and all-zero end points
        send_load(1023, 1023, 1023, 1023, 254);
        send_load(0, 0, 0, 0, 0);
        send_advance(1);

        run_random(500);
        wait_for_pixels();

        // phase 2: slow sender
        tx_idle_pct = 88;
        rx_idle_pct = 28;
        run_random(1000);
        wait_for_pixels();

        // phase 3: no idling, with one long receiver hold-off
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fork
            hold_receiver(HOLD_CYCLES);
            run_random(1500);
        join
        wait_for_pixels();
        repeat (8) @(posedge clk);

        $display("Covered %0d line loads and %0d checked pixels; %0d advances gave no pixel.",
                 board.lines_loaded, board.pixels_checked, board.dead_advances);
        $display("Three back-pressure phases, one %0d-cycle receiver hold-off; %0d mismatches.",
                 HOLD_CYCLES, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
